// ----- src/rph_pkg.sv -----
// rph_pkg: shared types and constants of the rolling polynomial hash
package rph_pkg;

    localparam int DATA_W   = 32;
    localparam int PROD_W   = 64;
    localparam int SUB_W    = 34;
    localparam int ADD_W    = 33;
    localparam int STEP_W   = 7;
    localparam int LEN_CFG_W = 7;
    localparam int CFG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN    = 2'd2;

    localparam logic [DATA_W-1:0]    MODULUS_RST    = 32'd1000000007;
    localparam logic [DATA_W-1:0]    MULTIPLIER_RST = 32'd3980;
    localparam logic [LEN_CFG_W-1:0] WIN_LEN_RST    = 7'd16;

    // datapath load operations
    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_POW_MULT  = 3'd1;
    localparam logic [2:0] OP_HASH_MULT = 3'd2;
    localparam logic [2:0] OP_POW_OLD   = 3'd3;
    localparam logic [2:0] OP_SUB       = 3'd4;
    localparam logic [2:0] OP_ADD       = 3'd5;

    typedef struct packed {
        logic       take;
        logic [2:0] load_op;
        logic       commit_power;
        logic       commit_hash;
        logic       finish;
    } rph_cmd_t;

    typedef struct packed {
        logic busy;
        logic filling;
        logic fill_zero;
    } rph_sts_t;

endpackage

// ----- src/rph_ifs.sv -----
// rph_ifs: handshake channels of the rolling polynomial hash
interface rph_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, data_byte, restart, input ready);
    modport sink (input valid, data_byte, restart, output ready);
endinterface

interface rph_hash_if;
    logic        valid;
    logic        ready;
    logic [31:0] fingerprint;
    logic        window_full;

    modport source (output valid, fingerprint, window_full, input ready);
    modport sink (input valid, fingerprint, window_full, output ready);
endinterface

interface rph_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rph_pkg::CFG_IDX_W-1:0]  index;
    logic [31:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/rph_datapath.sv -----
// rph_datapath: window memory, hash state, multiplier and bit-serial modular reducer
module rph_datapath #(
    parameter int MAX_WINDOW = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rph_pkg::rph_cmd_t cmd,
    output rph_pkg::rph_sts_t sts,
    input  logic [7:0]        data_byte,
    input  logic              restart,
    input  logic [31:0]       modulus,
    input  logic [31:0]       multiplier,
    input  logic [6:0]        window_length,
    output logic [31:0]       fingerprint,
    output logic              window_full
);
    import rph_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W = (CNT_W > LEN_CFG_W) ? CNT_W : LEN_CFG_W;

    logic [7:0]        win_mem [MAX_WINDOW];
    logic [PTR_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [DATA_W-1:0] hash_reg;
    logic [DATA_W-1:0] power_reg;
    logic [7:0]        byte_reg;
    logic [7:0]        old_reg;
    logic [PROD_W-1:0] shift_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DATA_W-1:0] fp_reg;
    logic              full_reg;

    logic [LEN_W-1:0]  k_len;
    logic [LEN_W-1:0]  pos_inc;
    logic [PTR_W-1:0]  pos_eff;
    logic [PTR_W-1:0]  pos_next;
    logic              filling;
    logic [CNT_W-1:0]  fill_new;
    logic              full_new;
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [PROD_W-1:0] product;
    logic [DATA_W:0]   span;
    logic [SUB_W-1:0]  sub_val;
    logic [ADD_W-1:0]  add_val;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   rem_diff;
    logic              rem_ge;

    // effective window length: zero acts as one, clamp at the memory depth
    always_comb
    begin
        if (window_length == '0)
            k_len = LEN_W'(1);
        else if (LEN_W'(window_length) > LEN_W'(MAX_WINDOW))
            k_len = LEN_W'(MAX_WINDOW);
        else
            k_len = LEN_W'(window_length);
    end

    assign pos_eff  = (LEN_W'(pos_reg) >= k_len) ? '0 : pos_reg;
    assign pos_inc  = LEN_W'(pos_eff) + LEN_W'(1);
    assign pos_next = (pos_inc >= k_len) ? '0 : pos_inc[PTR_W-1:0];
    assign filling  = LEN_W'(fill_reg) < k_len;
    assign fill_new = filling ? fill_reg + CNT_W'(1) : fill_reg;
    assign full_new = LEN_W'(fill_new) >= k_len;

    always_comb
    begin
        mul_a = power_reg;
        mul_b = multiplier;
        unique case (cmd.load_op)
            OP_HASH_MULT: mul_a = hash_reg;
            OP_POW_OLD:   mul_b = {24'b0, old_reg};
            default:      ;
        endcase
    end

    assign product = {32'b0, mul_a} * {32'b0, mul_b};

    // modulus zero means plain 2^32 wrap
    assign span    = (modulus == '0) ? {1'b1, 32'b0} : {1'b0, modulus};
    assign sub_val = {2'b0, hash_reg} + {1'b0, span} - {2'b0, rem_reg};
    assign add_val = {1'b0, hash_reg} + {25'b0, byte_reg};

    // one restoring step per cycle, msb of the shift register first
    assign rem_shift = {rem_reg, shift_reg[PROD_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, modulus};
    assign rem_diff  = rem_shift - {1'b0, modulus};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            unique case (cmd.load_op)
                OP_POW_MULT, OP_HASH_MULT, OP_POW_OLD:
                    cnt_reg <= STEP_W'(PROD_W);
                OP_SUB:
                    cnt_reg <= STEP_W'(SUB_W);
                OP_ADD:
                    cnt_reg <= STEP_W'(ADD_W);
                default:
                    if (cnt_reg != '0)
                        cnt_reg <= cnt_reg - STEP_W'(1);
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.load_op)
            OP_POW_MULT, OP_HASH_MULT, OP_POW_OLD:
            begin
                shift_reg <= product;
                rem_reg   <= '0;
            end
            OP_SUB:
            begin
                shift_reg <= {sub_val, {(PROD_W - SUB_W){1'b0}}};
                rem_reg   <= '0;
            end
            OP_ADD:
            begin
                shift_reg <= {add_val, {(PROD_W - ADD_W){1'b0}}};
                rem_reg   <= '0;
            end
            default:
                if (cnt_reg != '0)
                begin
                    shift_reg <= {shift_reg[PROD_W-2:0], 1'b0};
                    rem_reg   <= rem_ge ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
                end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            fill_reg  <= '0;
            hash_reg  <= '0;
            power_reg <= DATA_W'(1);
        end
        else
        begin
            if (cmd.take && restart)
            begin
                pos_reg   <= '0;
                fill_reg  <= '0;
                hash_reg  <= '0;
                power_reg <= DATA_W'(1);
            end
            if (cmd.commit_power)
                power_reg <= rem_reg;
            if (cmd.commit_hash)
                hash_reg <= rem_reg;
            if (cmd.finish)
            begin
                pos_reg  <= pos_next;
                fill_reg <= fill_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            byte_reg <= data_byte;
        if (cmd.finish)
        begin
            fp_reg   <= hash_reg;
            full_reg <= full_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            win_mem[pos_eff] <= byte_reg;
        old_reg <= win_mem[pos_eff];
    end

    assign sts.busy      = cnt_reg != '0;
    assign sts.filling   = filling;
    assign sts.fill_zero = fill_reg == '0;

    assign fingerprint = fp_reg;
    assign window_full = full_reg;

endmodule

// ----- src/rph_ctrl.sv -----
// rph_ctrl: sequencer that steps the datapath through one word's arithmetic
module rph_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output rph_pkg::rph_cmd_t cmd,
    input  rph_pkg::rph_sts_t sts
);
    import rph_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_POW_LD   = 4'd2;
    localparam logic [3:0] S_POW_RED  = 4'd3;
    localparam logic [3:0] S_OLD_LD   = 4'd4;
    localparam logic [3:0] S_OLD_RED  = 4'd5;
    localparam logic [3:0] S_SUB_LD   = 4'd6;
    localparam logic [3:0] S_SUB_RED  = 4'd7;
    localparam logic [3:0] S_HASH_LD  = 4'd8;
    localparam logic [3:0] S_HASH_RED = 4'd9;
    localparam logic [3:0] S_ADD_LD   = 4'd10;
    localparam logic [3:0] S_ADD_RED  = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_START;
                end
            S_START:
                if (!sts.filling)
                    state_next = S_OLD_LD;
                else if (sts.fill_zero)
                    state_next = S_HASH_LD;
                else
                    state_next = S_POW_LD;
            S_POW_LD:
            begin
                cmd.load_op = OP_POW_MULT;
                state_next  = S_POW_RED;
            end
            S_POW_RED:
                if (!sts.busy)
                begin
                    cmd.commit_power = 1'b1;
                    state_next       = S_HASH_LD;
                end
            S_OLD_LD:
            begin
                cmd.load_op = OP_POW_OLD;
                state_next  = S_OLD_RED;
            end
            S_OLD_RED:
                if (!sts.busy)
                    state_next = S_SUB_LD;
            S_SUB_LD:
            begin
                cmd.load_op = OP_SUB;
                state_next  = S_SUB_RED;
            end
            S_SUB_RED:
                if (!sts.busy)
                begin
                    cmd.commit_hash = 1'b1;
                    state_next      = S_HASH_LD;
                end
            S_HASH_LD:
            begin
                cmd.load_op = OP_HASH_MULT;
                state_next  = S_HASH_RED;
            end
            S_HASH_RED:
                if (!sts.busy)
                begin
                    cmd.commit_hash = 1'b1;
                    state_next      = S_ADD_LD;
                end
            S_ADD_LD:
            begin
                cmd.load_op = OP_ADD;
                state_next  = S_ADD_RED;
            end
            S_ADD_RED:
                if (!sts.busy)
                begin
                    cmd.commit_hash = 1'b1;
                    state_next      = S_DONE;
                end
            S_DONE:
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

// ----- src/rolling_polynomial_hash.sv -----
// rolling_polynomial_hash: top level with configuration registers
// Rolling polynomial hash over the last window_length bytes of a byte stream; each
// accepted word yields one word holding the fingerprint and the window-full flag. Words
// are handled one at a time. Products use one shared 32x32 multiplier; every product
// or sum runs through a bit-serial reducer retiring one bit per cycle, from 64 bits for
// a product, 34 for the leaving-byte subtract and 33 for the new-byte add. A window's
// first byte takes a hash product and add, a fill byte first a power product, a byte of
// a full window first a power times leaving byte product and the subtract. The output
// word sits in a register, so a stalled output does not block the next input word.
// Configuration must be written by the user only while idle; the block does not check.
module rolling_polynomial_hash #(
    parameter int MAX_WINDOW = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    rph_byte_if.sink     byte_in,
    rph_hash_if.source   hash_out,
    rph_cfg_if.sink      cfg
);
    import rph_pkg::*;

    logic [DATA_W-1:0]    modulus_reg;
    logic [DATA_W-1:0]    multiplier_reg;
    logic [LEN_CFG_W-1:0] win_len_reg;
    rph_cmd_t             cmd;
    rph_sts_t             sts;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg    <= MODULUS_RST;
            multiplier_reg <= MULTIPLIER_RST;
            win_len_reg    <= WIN_LEN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MODULUS:    modulus_reg    <= cfg.data;
                REG_MULTIPLIER: multiplier_reg <= cfg.data;
                REG_WIN_LEN:    win_len_reg    <= cfg.data[LEN_CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    rph_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (byte_in.valid),
        .in_ready  (byte_in.ready),
        .out_valid (hash_out.valid),
        .out_ready (hash_out.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rph_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .data_byte     (byte_in.data_byte),
        .restart       (byte_in.restart),
        .modulus       (modulus_reg),
        .multiplier    (multiplier_reg),
        .window_length (win_len_reg),
        .fingerprint   (hash_out.fingerprint),
        .window_full   (hash_out.window_full)
    );

endmodule

// ----- src/rph_checker.sv -----
// rph_checker: port-level checks of the rolling polynomial hash, bound to the top level
module rph_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] fingerprint,
    input logic        window_full
);

    // one word at a time: input closes right after a word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still open after a word was taken");

    // the arithmetic lies between accept and result, so no result can show up right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after input accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(fingerprint) && $stable(window_full))
        else $error("output word changed while stalled");

endmodule

bind rolling_polynomial_hash rph_checker u_rph_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (byte_in.valid),
    .in_ready    (byte_in.ready),
    .out_valid   (hash_out.valid),
    .out_ready   (hash_out.ready),
    .fingerprint (hash_out.fingerprint),
    .window_full (hash_out.window_full)
);
